/* rtl/bhash_pkg.sv */
package bhash_pkg;

    localparam int BUCKETS_DEF            = 5;
    localparam int ENTRIES_PER_BUCKET_DEF = 256;

    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_FULL,
        RES_HIT
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CNT,
        ST_CHK,
        ST_SCAN,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic      load;
        logic      mod_step;
        logic      cnt_read;
        logic      ins_write;
        logic      scan_start;
        logic      scan_step;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic op_lookup;
        logic bucket_full;
        logic bucket_empty;
        logic scan_done;
        logic scan_hit;
        logic out_free;
    } status_t;

endpackage

/* rtl/bhash_ctrl.sv */
module bhash_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bhash_pkg::status_t status,
    output bhash_pkg::cmd_t    cmd
);

    bhash_pkg::state_t state_reg;
    bhash_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bhash_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bhash_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bhash_pkg::ST_MOD;
                end
            end
            bhash_pkg::ST_MOD: begin
                if (status.mod_done) begin
                    state_next = bhash_pkg::ST_CNT;
                end
            end
            bhash_pkg::ST_CNT: begin
                state_next = bhash_pkg::ST_CHK;
            end
            bhash_pkg::ST_CHK: begin
                if (status.op_lookup && !status.bucket_empty) begin
                    state_next = bhash_pkg::ST_SCAN;
                end else begin
                    state_next = bhash_pkg::ST_REPLY;
                end
            end
            bhash_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = bhash_pkg::ST_REPLY;
                end
            end
            bhash_pkg::ST_REPLY: begin
                if (status.out_free) begin
                    state_next = bhash_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bhash_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        cmd.res_kind = bhash_pkg::RES_DONE;
        case (state_reg)
            bhash_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bhash_pkg::ST_MOD: begin
                cmd.mod_step = 1'b1;
            end
            bhash_pkg::ST_CNT: begin
                cmd.cnt_read = 1'b1;
            end
            bhash_pkg::ST_CHK: begin
                if (!status.op_lookup) begin
                    cmd.res_set = 1'b1;
                    if (status.bucket_full) begin
                        cmd.res_kind = bhash_pkg::RES_FULL;
                    end else begin
                        cmd.ins_write = 1'b1;
                    end
                end else if (status.bucket_empty) begin
                    cmd.res_set = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                end
            end
            bhash_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) begin
                    cmd.res_set = 1'b1;
                    if (status.scan_hit) begin
                        cmd.res_kind = bhash_pkg::RES_HIT;
                    end
                end
            end
            bhash_pkg::ST_REPLY: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/bhash_dp.sv */
module bhash_dp #(
    parameter int BUCKETS            = bhash_pkg::BUCKETS_DEF,
    parameter int ENTRIES_PER_BUCKET = bhash_pkg::ENTRIES_PER_BUCKET_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bhash_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bhash_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [bhash_pkg::M_TUSER_W-1:0]     m_tuser,
    input  bhash_pkg::cmd_t                     cmd,
    output bhash_pkg::status_t                  status
);

    localparam int KEY_W  = bhash_pkg::KEY_W;
    localparam int VAL_W  = bhash_pkg::VAL_W;
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DEPTH  = BUCKETS * ENTRIES_PER_BUCKET;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(ENTRIES_PER_BUCKET + 1);
    localparam int RCP_W  = KEY_W + 1;
    localparam int PROD_W = KEY_W + RCP_W;
    localparam int SHIFT  = KEY_W + $clog2(BUCKETS);
    localparam logic [63:0] RECIP_W =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RCP_W-1:0] RECIP     = RCP_W'(RECIP_W);
    localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);
    localparam logic [CW-1:0]    ENTRIES_C = CW'(ENTRIES_PER_BUCKET);

    bhash_pkg::entry_t entry_mem [DEPTH];
    logic [CW-1:0]     cnt_mem   [BUCKETS];
    logic [BUCKETS-1:0] cnt_valid_reg;

    logic                          op_reg;
    logic [KEY_W-1:0]              key_reg;
    logic [VAL_W-1:0]              val_reg;
    logic                          mod_phase_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [BW-1:0]                 rem_reg;
    logic [AW-1:0]                 base_reg;
    logic [CW-1:0]                 cnt_q_reg;
    logic                          cnt_vq_reg;
    logic [CW-1:0]                 scan_idx_reg;
    logic                          pend_reg;
    bhash_pkg::entry_t             rd_reg;
    bhash_pkg::res_kind_t          res_kind_reg;
    logic [VAL_W-1:0]              res_value_reg;
    logic                          m_tvalid_reg;
    logic [bhash_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bhash_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic [KEY_W-1:0] quot;
    logic [KEY_W-1:0] qmul;
    logic [KEY_W-1:0] rem_full;
    logic [BW-1:0]    bucket;
    logic [CW-1:0]    cnt_eff;
    logic             scan_issue;
    logic             scan_hit;
    logic [AW-1:0]    ins_addr;
    logic [AW-1:0]    scan_addr;

    assign quot      = KEY_W'(prod_reg >> SHIFT);
    assign qmul      = quot * BUCKETS_K;
    assign rem_full  = key_reg - qmul;
    assign bucket    = rem_reg;
    assign cnt_eff   = cnt_vq_reg ? cnt_q_reg : '0;
    assign scan_issue = scan_idx_reg < cnt_eff;
    assign scan_hit  = pend_reg && (rd_reg.key == key_reg);
    assign ins_addr  = base_reg + AW'(cnt_eff);
    assign scan_addr = base_reg + AW'(scan_idx_reg);

    assign status.mod_done     = mod_phase_reg;
    assign status.op_lookup    = (op_reg == bhash_pkg::OP_LOOKUP);
    assign status.bucket_full  = (cnt_eff == ENTRIES_C);
    assign status.bucket_empty = (cnt_eff == '0);
    assign status.scan_hit     = scan_hit;
    assign status.scan_done    = pend_reg && (scan_hit || scan_idx_reg == cnt_eff);
    assign status.out_free     = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_tuser;
            key_reg       <= s_tdata[KEY_W-1:0];
            val_reg       <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            mod_phase_reg <= 1'b0;
        end
        if (cmd.mod_step) begin
            if (!mod_phase_reg) begin
                prod_reg      <= PROD_W'(key_reg) * PROD_W'(RECIP);
                mod_phase_reg <= 1'b1;
            end else begin
                rem_reg <= rem_full[BW-1:0];
            end
        end
        if (cmd.cnt_read) begin
            cnt_q_reg  <= cnt_mem[bucket];
            cnt_vq_reg <= cnt_valid_reg[bucket];
            base_reg   <= AW'(int'(bucket) * ENTRIES_PER_BUCKET);
        end
        if (cmd.ins_write) begin
            entry_mem[ins_addr] <= '{value: val_reg, key: key_reg};
            cnt_mem[bucket]     <= cnt_eff + 1'b1;
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end
        if (cmd.scan_step) begin
            pend_reg <= scan_issue;
            if (scan_issue) begin
                rd_reg       <= entry_mem[scan_addr];
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (cmd.res_set) begin
            res_kind_reg  <= cmd.res_kind;
            res_value_reg <= (cmd.res_kind == bhash_pkg::RES_HIT) ? rd_reg.value : '0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= res_value_reg;
            m_tuser_reg <= {res_kind_reg == bhash_pkg::RES_HIT,
                            res_kind_reg == bhash_pkg::RES_FULL};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.ins_write) begin
                cnt_valid_reg[bucket] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/bucketed_hash_insert_lookup.sv */
// Channel   Dir  tdata (low bit up)              tuser (low bit up)
// s_        in   key[30:0], data_value[62:31]     opcode
// m_        out  read_value[31:0]                 status, found
//
// One transaction at a time: accept, key modulo BUCKETS by reciprocal multiply
// (product, then remainder), the bucket fill count read and insert, for a lookup
// of a non-empty bucket a scan of its filled entries through the registered RAM
// port, then the output register.
// aresetn clears the fill-count valid bits, so the table is empty at once.
// The result register holds until m_tready; the next item is taken meanwhile.
module bucketed_hash_insert_lookup #(
    parameter int BUCKETS            = bhash_pkg::BUCKETS_DEF,
    parameter int ENTRIES_PER_BUCKET = bhash_pkg::ENTRIES_PER_BUCKET_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bhash_pkg::S_TDATA_W-1:0] s_tdata,   // key, data_value
    input  logic                            s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bhash_pkg::M_TDATA_W-1:0] m_tdata,   // read_value
    output logic [bhash_pkg::M_TUSER_W-1:0] m_tuser    // status, found
);

    bhash_pkg::cmd_t    cmd;
    bhash_pkg::status_t status;

    bhash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bhash_dp #(
        .BUCKETS            (BUCKETS),
        .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
